>>> hdl/ryc_pkg.sv
// Shared types and constants for the RGB/YIQ color converter.
// Pixel and result beat types, the coefficient matrices and the fixed-point scaling.
// No dependencies.
`timescale 1ns / 1ps

package ryc_pkg;

  // Result fraction bits
  localparam int FRAC_BITS = 14;
  localparam longint ONE = 64'sd1 << FRAC_BITS;

  // Forward I and Q limits, rounded to nearest like every result
  localparam longint LIM_I = (2 * 5957 * ONE + 10000) / 20000;
  localparam longint LIM_Q = (2 * 5226 * ONE + 10000) / 20000;
  localparam longint LIM_OUT [3] = '{ONE, LIM_I, LIM_Q};

  // Every matrix sum is a value over DEN = 2^8 * HALF_K.
  localparam longint DEN    = 64'sd1020000000;
  localparam longint HALF_K = DEN >> 8;
  localparam longint DIV    = 2 * HALF_K;

  // YIQ byte decode, in the same units: (b - 128) * IQ_SCALE, clamped
  localparam longint IQ_SCALE = 10625;
  localparam longint IQ_LIM_I = 5957 * 102;
  localparam longint IQ_LIM_Q = 5226 * 102;

  localparam int OP_W   = 21;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 34;
  localparam int MAG_W  = 30;
  localparam int X_W    = MAG_W + FRAC_BITS - 7 + 1;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int RES_W  = Q_W + 1;

  // Reciprocal for the divide by DIV: top 30 bits of x times RECIP
  localparam int XHI_W   = 30;
  localparam int X_SH    = X_W - XHI_W;
  localparam int RECIP_E = 52;
  localparam int R_SH    = RECIP_E - X_SH;
  localparam int RECIP_W = 30;
  localparam longint RECIP = (64'sd1 <<< RECIP_E) / DIV;

  typedef logic signed [23:0] coef_t;

  // [direction][output][operand]; forward rows are pre-scaled by 4000
  localparam coef_t COEF [2][3][3] = '{
    '{'{ 24'sd1196000,  24'sd2348000,  24'sd456000},
      '{ 24'sd2384000, -24'sd1096000, -24'sd1288000},
      '{ 24'sd844000,  -24'sd2092000,  24'sd1248000}},
    '{'{ 24'sd4000000,  24'sd956,      24'sd621},
      '{ 24'sd4000000, -24'sd272,     -24'sd647},
      '{ 24'sd4000000, -24'sd1106,     24'sd1703}}
  };

  typedef enum logic {
    DIR_RGB2YIQ = 1'b0,
    DIR_YIQ2RGB = 1'b1
  } dir_t;

  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
  } pix_t;

  typedef struct packed {
    logic        [14:0] comp_a;
    logic signed [15:0] comp_b;
    logic signed [15:0] comp_c;
  } res_t;

endpackage

>>> hdl/ryc_const_div.sv
// Two-stage floor divide by the fixed divisor ryc_pkg::DIV.
// Reciprocal estimate then one remainder correction step.
// Depends on ryc_pkg.
`timescale 1ns / 1ps

module ryc_const_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ryc_pkg::X_W-1:0]    x,
  output logic [ryc_pkg::Q_W-1:0]    q
);

  logic [ryc_pkg::XHI_W-1:0]                     x_hi;
  logic [ryc_pkg::XHI_W+ryc_pkg::RECIP_W-1:0]    prod;
  logic [ryc_pkg::X_W-1:0]                       x_d;
  logic [ryc_pkg::Q_W-1:0]                       qe;
  logic [ryc_pkg::X_W-1:0]                       back;
  logic [ryc_pkg::X_W-1:0]                       rem;

  // estimate is never above the true quotient and at most one below
  assign x_hi = x[ryc_pkg::X_W-1 -: ryc_pkg::XHI_W];
  assign prod = (ryc_pkg::XHI_W + ryc_pkg::RECIP_W)'(x_hi)
              * (ryc_pkg::XHI_W + ryc_pkg::RECIP_W)'(ryc_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      x_d <= x;
      qe  <= prod[ryc_pkg::R_SH +: ryc_pkg::Q_W];
    end
  end

  assign back = ryc_pkg::X_W'(qe) * ryc_pkg::X_W'(ryc_pkg::DIV);
  assign rem  = x_d - back;

  always_ff @(posedge clk) begin
    if (en) begin
      q <= qe + ryc_pkg::Q_W'(rem >= ryc_pkg::X_W'(ryc_pkg::DIV));
    end
  end

endmodule

>>> hdl/rgb_yiq_color_converter.sv
// Top level of the RGB/YIQ pixel converter: eight register stages, one pixel per beat.
// Depends on ryc_pkg and ryc_const_div.
`timescale 1ns / 1ps
//
// Usage
//   pix channel: one pixel (byte_a, byte_b, byte_c) per beat, pix_valid/pix_stall.
//   res channel: one result (comp_a, comp_b, comp_c) per pixel, res_valid/res_stall,
//     signed (comp_a unsigned) fixed point with FRAC_BITS fraction bits, rounded to nearest.
//   cfg channel: cfg_data selects the direction, 0 = RGB to YIQ, 1 = YIQ to RGB.
//     Always ready; write it only while no pixel is in flight.
// Throughput: one pixel per clock while not stalled, set by the fully pipelined datapath.
// Pipeline: res_valid follows the accepting edge through each stage register below, barring stalls.
//   Stages: input, operand decode, matrix products, sums, magnitude and clamp,
//   reciprocal estimate, remainder correction, output clamp and sign.
// Stall: when res_valid is held by res_stall the whole pipeline freezes and
//   pix_stall rises in the same cycle; nothing is dropped or repeated.
// Reset (rst, synchronous): clears all valid bits and sets direction to 0.
//
module rgb_yiq_color_converter (
  input  logic          clk,
  input  logic          rst,
  input  logic          pix_valid,
  output logic          pix_stall,
  input  ryc_pkg::pix_t pix,
  output logic          res_valid,
  input  logic          res_stall,
  output ryc_pkg::res_t res,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);

  ryc_pkg::dir_t direction;
  logic          en;
  logic [6:0]    vld;
  logic [7:0]    dirp;

  ryc_pkg::pix_t pix_s1;

  logic signed [ryc_pkg::OP_W-1:0]   op_next [3];
  logic signed [ryc_pkg::OP_W-1:0]   op_s2   [3];
  logic signed [44:0]                prod_full [3][3];
  logic signed [ryc_pkg::PROD_W-1:0] prod_s3 [3][3];
  logic signed [ryc_pkg::SUM_W-1:0]  sum_next [3];
  logic signed [ryc_pkg::SUM_W-1:0]  sum_s4  [3];
  logic signed [ryc_pkg::SUM_W-1:0]  absn    [3];
  logic [ryc_pkg::MAG_W-1:0]         mag     [3];
  logic [ryc_pkg::X_W-1:0]           x_next  [3];
  logic [ryc_pkg::X_W-1:0]           x_s5    [3];
  logic [2:0]                        neg_s5;
  logic [2:0]                        neg_s6;
  logic [2:0]                        neg_s7;
  logic [ryc_pkg::Q_W-1:0]           q_s7    [3];
  logic [ryc_pkg::Q_W-1:0]           lim     [3];
  logic [ryc_pkg::Q_W-1:0]           m       [3];
  logic signed [ryc_pkg::RES_W-1:0]  sres    [3];
  ryc_pkg::res_t                     res_next;

  // I/Q byte to operand: offset, scale, clamp to the decode limit
  function automatic logic signed [ryc_pkg::OP_W-1:0] iq_operand(logic [7:0] bv,
                                                                longint lim_v);
    logic signed [8:0]  off;
    logic signed [23:0] full;
    off  = $signed({1'b0, bv}) - 9'sd128;
    full = 24'(off) * 24'(ryc_pkg::IQ_SCALE);
    priority if (full > 24'(lim_v)) begin
      return ryc_pkg::OP_W'(lim_v);
    end else if (full < -24'(lim_v)) begin
      return -ryc_pkg::OP_W'(lim_v);
    end else begin
      return ryc_pkg::OP_W'(full);
    end
  endfunction

  // ---------------- control ----------------
  assign cfg_ready = 1'b1;
  assign en        = !(res_valid && res_stall);
  assign pix_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= ryc_pkg::DIR_RGB2YIQ;
    end else if (cfg_valid && cfg_ready) begin
      direction <= ryc_pkg::dir_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[5:0], pix_valid};
      res_valid <= vld[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dirp <= {dirp[6:0], direction};
    end
  end

  // ---------------- stage 1: input ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      pix_s1 <= pix;
    end
  end

  // ---------------- stage 2: operands ----------------
  always_comb begin
    op_next[0] = ryc_pkg::OP_W'($signed({1'b0, pix_s1.byte_a}));
    if (dirp[0] == ryc_pkg::DIR_YIQ2RGB) begin
      op_next[1] = iq_operand(pix_s1.byte_b, ryc_pkg::IQ_LIM_I);
      op_next[2] = iq_operand(pix_s1.byte_c, ryc_pkg::IQ_LIM_Q);
    end else begin
      op_next[1] = ryc_pkg::OP_W'($signed({1'b0, pix_s1.byte_b}));
      op_next[2] = ryc_pkg::OP_W'($signed({1'b0, pix_s1.byte_c}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_s2 <= op_next;
    end
  end

  // ---------------- stage 3: matrix products ----------------
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod_full[k][j] = 45'(op_s2[j]) * 45'(ryc_pkg::COEF[dirp[1]][k][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          prod_s3[k][j] <= prod_full[k][j][ryc_pkg::PROD_W-1:0];
        end
      end
    end
  end

  // ---------------- stage 4: sums ----------------
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_next[k] = ryc_pkg::SUM_W'(prod_s3[k][0]) + ryc_pkg::SUM_W'(prod_s3[k][1])
                  + ryc_pkg::SUM_W'(prod_s3[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_s4 <= sum_next;
    end
  end

  // ---------------- stage 5: magnitude, saturate at 1.0, rounding bias ----------------
  // no exact ties exist in either direction, so rounding |n| and re-signing is exact
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      absn[k] = sum_s4[k][ryc_pkg::SUM_W-1] ? -sum_s4[k] : sum_s4[k];
      if (absn[k] > ryc_pkg::SUM_W'(ryc_pkg::DEN)) begin
        mag[k] = ryc_pkg::MAG_W'(ryc_pkg::DEN);
      end else begin
        mag[k] = absn[k][ryc_pkg::MAG_W-1:0];
      end
      x_next[k] = (ryc_pkg::X_W'(mag[k]) << (ryc_pkg::FRAC_BITS - 7))
                + ryc_pkg::X_W'(ryc_pkg::HALF_K);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s5   <= x_next;
      neg_s5 <= {sum_s4[2][ryc_pkg::SUM_W-1], sum_s4[1][ryc_pkg::SUM_W-1],
                 sum_s4[0][ryc_pkg::SUM_W-1]};
      neg_s6 <= neg_s5;
      neg_s7 <= neg_s6;
    end
  end

  // ---------------- stages 6 and 7: divide ----------------
  for (genvar k = 0; k < 3; k++) begin : g_div
    ryc_const_div u_div (
      .clk (clk),
      .en  (en),
      .x   (x_s5[k]),
      .q   (q_s7[k])
    );
  end

  // ---------------- stage 8: output clamp and sign ----------------
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lim[k] = (dirp[6] == ryc_pkg::DIR_YIQ2RGB) ? ryc_pkg::Q_W'(ryc_pkg::ONE)
                                                  : ryc_pkg::Q_W'(ryc_pkg::LIM_OUT[k]);
      m[k] = (q_s7[k] > lim[k]) ? lim[k] : q_s7[k];
      if (!neg_s7[k]) begin
        sres[k] = ryc_pkg::RES_W'(m[k]);
      end else if (dirp[6] == ryc_pkg::DIR_YIQ2RGB) begin
        sres[k] = '0;
      end else begin
        sres[k] = -ryc_pkg::RES_W'(m[k]);
      end
    end
    res_next.comp_a = 15'(sres[0]);
    res_next.comp_b = 16'(sres[1]);
    res_next.comp_c = 16'(sres[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

  // ---------------- checks ----------------
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> $stable(vld))
    else $error("pipeline moved while the output beat was stalled");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.comp_a <= 15'(ryc_pkg::ONE))
    else $error("comp_a above 1.0");

  a_rgb_nonneg: assert property (@(posedge clk) disable iff (rst)
    (res_valid && dirp[7] == ryc_pkg::DIR_YIQ2RGB) |-> (!res.comp_b[15] && !res.comp_c[15]))
    else $error("negative RGB component");

  a_iq_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && dirp[7] == ryc_pkg::DIR_RGB2YIQ)
      |-> (res.comp_b <= 16'(ryc_pkg::LIM_I) && res.comp_b >= -16'(ryc_pkg::LIM_I)
           && res.comp_c <= 16'(ryc_pkg::LIM_Q) && res.comp_c >= -16'(ryc_pkg::LIM_Q)))
    else $error("I or Q outside its limit");

endmodule

>>> dv/rgb_yiq_color_converter_tb.sv
// Self-checking testbench for rgb_yiq_color_converter: directed pixel table, then random
// pixels in both directions under sender idling and receiver stalls.
// Depends on ryc_pkg and the converter RTL.
`timescale 1ns / 1ps

module rgb_yiq_color_converter_tb;

  localparam longint FX_ONE      = 64'sd1 << ryc_pkg::FRAC_BITS;
  localparam int     RAND_PIXELS = 100;     // per direction per idling phase
  localparam int     DRAIN_WAIT  = 16;      // pipeline is 8 deep
  localparam int     CYCLE_LIMIT = 400000;

  typedef struct packed {
    ryc_pkg::dir_t dir;
    ryc_pkg::pix_t px;
    logic          has_exp;
    ryc_pkg::res_t exp_res;
  } pix_case_t;

  localparam ryc_pkg::res_t NO_EXP = '0;
  localparam int            N_CASES = 24;

  // Typed results only where obvious: black and white in both directions.
  localparam pix_case_t PIX_CASES [N_CASES] = '{
    '{ryc_pkg::DIR_RGB2YIQ, '{8'd0, 8'd0, 8'd0}, 1'b1,
      '{15'd0, 16'sd0, 16'sd0}},
    '{ryc_pkg::DIR_RGB2YIQ, '{8'd255, 8'd255, 8'd255}, 1'b1,
      '{15'd16384, 16'sd0, 16'sd0}},
    '{ryc_pkg::DIR_RGB2YIQ, '{8'd255, 8'd0,   8'd0},   1'b0, NO_EXP},
    '{ryc_pkg::DIR_RGB2YIQ, '{8'd0,   8'd255, 8'd0},   1'b0, NO_EXP},
    '{ryc_pkg::DIR_RGB2YIQ, '{8'd0,   8'd0,   8'd255}, 1'b0, NO_EXP},
    '{ryc_pkg::DIR_RGB2YIQ, '{8'd255, 8'd255, 8'd0},   1'b0, NO_EXP},
    '{ryc_pkg::DIR_RGB2YIQ, '{8'd0,   8'd255, 8'd255}, 1'b0, NO_EXP},
    '{ryc_pkg::DIR_RGB2YIQ, '{8'd255, 8'd0,   8'd255}, 1'b0, NO_EXP},
    '{ryc_pkg::DIR_RGB2YIQ, '{8'd128, 8'd128, 8'd128}, 1'b0, NO_EXP},
    '{ryc_pkg::DIR_RGB2YIQ, '{8'd1,   8'd2,   8'd3},   1'b0, NO_EXP},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd0, 8'd128, 8'd128}, 1'b1,
      '{15'd0, 16'sd0, 16'sd0}},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd255, 8'd128, 8'd128}, 1'b1,
      '{15'd16384, 16'sd16384, 16'sd16384}},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd0,   8'd0,   8'd0},   1'b0, NO_EXP},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd255, 8'd255, 8'd255}, 1'b0, NO_EXP},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd0,   8'd255, 8'd0},   1'b0, NO_EXP},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd255, 8'd0,   8'd255}, 1'b0, NO_EXP},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd128, 8'd185, 8'd128}, 1'b0, NO_EXP},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd128, 8'd186, 8'd128}, 1'b0, NO_EXP},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd128, 8'd70,  8'd128}, 1'b0, NO_EXP},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd128, 8'd71,  8'd128}, 1'b0, NO_EXP},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd128, 8'd128, 8'd178}, 1'b0, NO_EXP},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd128, 8'd128, 8'd179}, 1'b0, NO_EXP},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd128, 8'd128, 8'd77},  1'b0, NO_EXP},
    '{ryc_pkg::DIR_YIQ2RGB, '{8'd255, 8'd255, 8'd0},   1'b0, NO_EXP}
  };

  logic          clk = 1'b0;
  logic          rst;
  logic          pix_valid;
  logic          pix_stall;
  ryc_pkg::pix_t pix;
  logic          res_valid;
  logic          res_stall;
  ryc_pkg::res_t res;
  logic          cfg_valid;
  logic          cfg_ready;
  logic          cfg_data;

  ryc_pkg::res_t pending_res [$];
  ryc_pkg::dir_t cur_dir;
  int            idle_pct;
  int            stall_pct;
  int            errors = 0;
  int            cycles = 0;

  rgb_yiq_color_converter uut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Round num/den to nearest, ties toward +inf; den > 0.
  function automatic longint round_nearest(longint num, longint den);
    longint x;
    longint y;
    longint q;
    x = 2 * num + den;
    y = 2 * den;
    q = x / y;
    if ((x % y) != 0 && x < 0) q--;
    return q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic ryc_pkg::res_t convert_pixel(ryc_pkg::dir_t d, ryc_pkg::pix_t p);
    longint        a;
    longint        b;
    longint        c;
    longint        r0;
    longint        r1;
    longint        r2;
    longint        lim_i;
    longint        lim_q;
    longint        scale;
    longint        y;
    longint        i;
    longint        q;
    ryc_pkg::res_t r;
    a = longint'(p.byte_a);
    b = longint'(p.byte_b);
    c = longint'(p.byte_c);
    if (d == ryc_pkg::DIR_RGB2YIQ) begin
      // sums are over 255 * 1000
      lim_i = round_nearest(5957 * FX_ONE, 10000);
      lim_q = round_nearest(5226 * FX_ONE, 10000);
      r0 = clip(round_nearest((299 * a + 587 * b + 114 * c) * FX_ONE, 255000), 0, FX_ONE);
      r1 = clip(round_nearest((596 * a - 274 * b - 322 * c) * FX_ONE, 255000),
                -lim_i, lim_i);
      r2 = clip(round_nearest((211 * a - 523 * b + 312 * c) * FX_ONE, 255000),
                -lim_q, lim_q);
    end else begin
      // inputs over 255 * 96 * 10000, clamped before the matrix
      scale = 64'sd255 * 96 * 10000;
      y = a * 96 * 10000;
      i = clip((b - 128) * 255 * 10000, -5957 * 255 * 96, 5957 * 255 * 96);
      q = clip((c - 128) * 255 * 10000, -5226 * 255 * 96, 5226 * 255 * 96);
      r0 = clip(round_nearest((1000 * y + 956 * i + 621 * q) * FX_ONE, scale * 1000),
                0, FX_ONE);
      r1 = clip(round_nearest((1000 * y - 272 * i - 647 * q) * FX_ONE, scale * 1000),
                0, FX_ONE);
      r2 = clip(round_nearest((1000 * y - 1106 * i + 1703 * q) * FX_ONE, scale * 1000),
                0, FX_ONE);
    end
    r.comp_a = r0[14:0];
    r.comp_b = r1[15:0];
    r.comp_c = r2[15:0];
    return r;
  endfunction

  // Biased toward the ends and the YIQ midpoint so the clamps get hit.
  function automatic logic [7:0] pick_byte();
    unique case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      3: return 8'($urandom_range(60, 196));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(ryc_pkg::pix_t px, logic has_exp, ryc_pkg::res_t exp_res);
    while ($urandom_range(99) < idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= px;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    pending_res.push_back(has_exp ? exp_res : convert_pixel(cur_dir, px));
  endtask

  task automatic drain();
    pix_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_direction(ryc_pkg::dir_t d);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_dir = d;
  endtask

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    ryc_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result beat %0d %0d %0d", $time,
                 res.comp_a, res.comp_b, res.comp_c);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (res.comp_a !== want.comp_a) begin
          $display("%0t: comp_a expected %0d, got %0d", $time, want.comp_a, res.comp_a);
          errors++;
        end
        if (res.comp_b !== want.comp_b) begin
          $display("%0t: comp_b expected %0d, got %0d", $time, want.comp_b, res.comp_b);
          errors++;
        end
        if (res.comp_c !== want.comp_c) begin
          $display("%0t: comp_c expected %0d, got %0d", $time, want.comp_c, res.comp_c);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    ryc_pkg::pix_t px;
    idle_pct  = 0;
    stall_pct = 0;
    cur_dir   = ryc_pkg::DIR_RGB2YIQ;
    rst       <= 1'b1;
    pix_valid <= 1'b0;
    pix       <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_direction(ryc_pkg::DIR_RGB2YIQ);
    for (int n = 0; n < N_CASES; n++) begin
      if (PIX_CASES[n].dir != cur_dir) set_direction(PIX_CASES[n].dir);
      send_pixel(PIX_CASES[n].px, PIX_CASES[n].has_exp, PIX_CASES[n].exp_res);
    end

    // idling phases: none, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      for (int d = 0; d < 2; d++) begin
        set_direction(d == 0 ? ryc_pkg::DIR_RGB2YIQ : ryc_pkg::DIR_YIQ2RGB);
        idle_pct  = (ph == 1) ? 79 : (ph == 3) ? 23 : 0;
        stall_pct = (ph == 2) ? 79 : (ph == 3) ? 23 : 0;
        for (int n = 0; n < RAND_PIXELS; n++) begin
          px.byte_a = pick_byte();
          px.byte_b = pick_byte();
          px.byte_c = pick_byte();
          send_pixel(px, 1'b0, NO_EXP);
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
